@@ src/otq_pkg.sv @@
// package for the ordered timer queue: constants, request codes, shared types
// no dependencies
`timescale 1ns / 1ps
package otq_pkg;
  localparam int TIMER_SLOTS = 32;
  localparam int SLOT_W = $clog2(TIMER_SLOTS);
  localparam int MAX_RESULTS = 32;
  localparam int NF_W = $clog2(MAX_RESULTS + 1);
  localparam int SEQ_W = 20;
  localparam int TIME_W = 44;
  localparam logic [63:0] NO_EXPIRY = 64'hffff_ffff_ffff_ffff;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {REQ_CREATE = 2'd0, REQ_CANCEL = 2'd1, REQ_CHECK = 2'd2,
                            REQ_NONE = 2'd3} req_t;
  typedef enum logic [1:0] {ST_OK = 2'd0, ST_NONE = 2'd1, ST_FULL = 2'd2,
                            ST_OVF = 2'd3} status_t;

  // classified request handed from front to back
  typedef struct packed {
    req_t              req;
    logic              ovf;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] expiry;
    logic [63:0]       id;
    logic [15:0]       tag;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] id;
    logic [15:0] tag;
    logic [63:0] next_expiry;
    logic        last;
  } res_t;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_ACT, S_EMIT, S_WAIT} bstate_t;
endpackage

@@ src/ordered_timer_queue.sv @@
// top level of the ordered timer queue: front classifier, command queue, back engine
// depends on otq_pkg, otq_front, otq_back
`timescale 1ns / 1ps
// Timer table of 32 slots keyed by (expiry << 20) | sequence. Each request is
// taken by the front part into a two-entry command queue; the back part walks
// the slot memory one entry per cycle, and a check does one more slot scan for
// every fired timer. A check emits its fired timers in key order, tlast on the
// final word.
module ordered_timer_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,  // req_type
  input  logic [159:0] in_tdata,  // now_ms[43:0], delay_ms[75:44], timer_id[139:76],
                                  // callback_tag[155:140], zero fill
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [1:0]   out_tuser, // status
  output logic [143:0] out_tdata, // result_id[63:0], result_tag[79:64], next_expiry[143:80]
  output logic         out_tlast
);
  logic cmd_valid, cmd_ready;
  otq_pkg::cmd_t cmd;
  otq_pkg::res_t res;

  otq_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .req_type(in_tuser), .now_ms(in_tdata[43:0]), .delay_ms(in_tdata[75:44]),
    .timer_id(in_tdata[139:76]), .callback_tag(in_tdata[155:140]),
    .cmd_valid, .cmd_ready, .cmd
  );
  otq_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd,
    .res_valid(out_tvalid), .res_ready(out_tready), .res
  );
  assign out_tuser = res.status;
  assign out_tdata = {res.next_expiry, res.tag, res.id};
  assign out_tlast = res.last;
endmodule

@@ src/otq_front.sv @@
// front part: accepts requests, computes expiry and overflow, queues commands
// depends on otq_pkg
`timescale 1ns / 1ps
module otq_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           req_type,
  input  logic [43:0]          now_ms,
  input  logic [31:0]          delay_ms,
  input  logic [63:0]          timer_id,
  input  logic [15:0]          callback_tag,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output otq_pkg::cmd_t        cmd
);
  otq_pkg::cmd_t q_r [otq_pkg::QDEPTH];
  logic [otq_pkg::QPTR_W-1:0] wp_r, rp_r;
  logic [otq_pkg::QCNT_W-1:0] cnt_r;
  logic [44:0] sum;
  otq_pkg::cmd_t c;
  logic push, pop;

  assign sum = {1'b0, now_ms} + {13'd0, delay_ms};
  always_comb begin
    c.req = otq_pkg::req_t'(req_type);
    c.ovf = sum[44];
    c.now = now_ms;
    c.expiry = sum[43:0];
    c.id = timer_id;
    c.tag = callback_tag;
  end
  assign in_ready = (cnt_r != otq_pkg::QCNT_W'(otq_pkg::QDEPTH));
  assign push = in_valid && in_ready;
  assign cmd_valid = (cnt_r != '0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= c;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + otq_pkg::QPTR_W'(1);
      if (pop) rp_r <= rp_r + otq_pkg::QPTR_W'(1);
      cnt_r <= cnt_r + otq_pkg::QCNT_W'(push) - otq_pkg::QCNT_W'(pop);
    end
  end
endmodule

@@ src/otq_back.sv @@
// back part: slot table, scans for free slot, match and minimum, emits results
// depends on otq_pkg
`timescale 1ns / 1ps
module otq_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  otq_pkg::cmd_t  cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output otq_pkg::res_t  res
);
  localparam int N = otq_pkg::TIMER_SLOTS;
  localparam int SW = otq_pkg::SLOT_W;

  logic [63:0] key_mem [N];
  logic [15:0] tag_mem [N];
  logic [N-1:0] valid_r;
  logic [otq_pkg::SEQ_W-1:0] seq_r;
  logic [63:0] hint_r, hint_nxt;
  otq_pkg::bstate_t st_r, st_nxt;
  otq_pkg::cmd_t c_r;
  logic [SW:0] idx_r, idx_nxt;
  logic [63:0] rd_key_r;
  logic        rd_v_r, rd_live_r;
  logic [SW-1:0] rd_idx_r;
  logic        free_f_r, free_f_nxt, match_f_r, match_f_nxt, min_f_r, min_f_nxt;
  logic [SW-1:0] free_i_r, free_i_nxt, match_i_r, match_i_nxt, min_i_r, min_i_nxt;
  logic [63:0] min_k_r, min_k_nxt, skey;
  logic        gt_f_r, gt_f_nxt;
  logic [otq_pkg::TIME_W-1:0] gt_e_r, gt_e_nxt;
  logic [otq_pkg::NF_W-1:0]  nfired_r, nfired_nxt;
  logic        started_r, started_nxt;
  otq_pkg::res_t res_r, res_nxt;
  logic        res_v_r, res_v_nxt;
  logic        wr_en, clr_en;
  logic [SW-1:0] wr_i, clr_i;
  logic [SW-1:0] rd_addr;
  logic [otq_pkg::TIME_W-1:0] me;

  // search key: new key for create, id for cancel
  assign skey = (c_r.req == otq_pkg::REQ_CREATE) ?
                {c_r.expiry, seq_r + otq_pkg::SEQ_W'(1)} : c_r.id;
  assign rd_addr = idx_r[SW-1:0];
  assign me = min_k_r[63:otq_pkg::SEQ_W];
  assign res_valid = res_v_r;
  assign res = res_r;

  always_ff @(posedge clk) begin
    rd_key_r <= key_mem[rd_addr];
    rd_idx_r <= rd_addr;
    if (wr_en) begin
      key_mem[wr_i] <= skey;
      tag_mem[wr_i] <= c_r.tag;
    end
  end

  always_comb begin
    st_nxt = st_r; idx_nxt = idx_r; hint_nxt = hint_r;
    free_f_nxt = free_f_r; free_i_nxt = free_i_r;
    match_f_nxt = match_f_r; match_i_nxt = match_i_r;
    min_f_nxt = min_f_r; min_i_nxt = min_i_r; min_k_nxt = min_k_r;
    gt_f_nxt = gt_f_r; gt_e_nxt = gt_e_r;
    nfired_nxt = nfired_r; started_nxt = started_r;
    res_nxt = res_r; res_v_nxt = res_v_r && !res_ready;
    cmd_ready = 1'b0; wr_en = 1'b0; clr_en = 1'b0;
    wr_i = free_i_r; clr_i = match_i_r;
    case (st_r)
      otq_pkg::S_IDLE: begin
        cmd_ready = 1'b1;
        nfired_nxt = '0; started_nxt = 1'b0;
        if (cmd_valid) begin
          idx_nxt = '0; st_nxt = otq_pkg::S_SCAN;
          free_f_nxt = 1'b0; match_f_nxt = 1'b0; min_f_nxt = 1'b0;
          gt_f_nxt = 1'b0;
        end
      end
      otq_pkg::S_SCAN: begin
        // one slot read per cycle, compared in the cycle after the read
        if (rd_live_r) begin
          if (!valid_r[rd_idx_r] && !free_f_r) begin
            free_f_nxt = 1'b1; free_i_nxt = rd_idx_r;
          end
          if (rd_v_r && rd_key_r == skey && !match_f_r) begin
            match_f_nxt = 1'b1; match_i_nxt = rd_idx_r;
          end
          if (rd_v_r && (!min_f_r || rd_key_r < min_k_r)) begin
            min_f_nxt = 1'b1; min_i_nxt = rd_idx_r; min_k_nxt = rd_key_r;
          end
          // earliest expiry still in the future: the next expiry that fired words carry
          if (rd_v_r && rd_key_r[63:otq_pkg::SEQ_W] > c_r.now &&
              (!gt_f_r || rd_key_r[63:otq_pkg::SEQ_W] < gt_e_r)) begin
            gt_f_nxt = 1'b1; gt_e_nxt = rd_key_r[63:otq_pkg::SEQ_W];
          end
        end
        if (idx_r == (SW+1)'(N)) begin
          if (!rd_live_r) st_nxt = otq_pkg::S_ACT;
        end else idx_nxt = idx_r + (SW+1)'(1);
      end
      otq_pkg::S_ACT: begin
        if (!res_v_r || res_ready) begin
          res_v_nxt = 1'b1;
          res_nxt = '{otq_pkg::ST_NONE, 64'd0, 16'd0, hint_r, 1'b1};
          st_nxt = otq_pkg::S_IDLE;
          case (c_r.req)
            otq_pkg::REQ_CREATE: begin
              if (c_r.ovf) res_nxt.status = otq_pkg::ST_OVF;
              else if (!free_f_r) res_nxt.status = otq_pkg::ST_FULL;
              else begin
                wr_en = !match_f_r;
                if (hint_r > {20'd0, c_r.expiry} || hint_r < {20'd0, c_r.now})
                  hint_nxt = {20'd0, c_r.expiry};
                res_nxt = '{otq_pkg::ST_OK, skey, 16'd0, hint_nxt, 1'b1};
              end
            end
            otq_pkg::REQ_CANCEL: begin
              res_nxt.id = c_r.id;
              if (match_f_r) begin
                clr_en = 1'b1; res_nxt.status = otq_pkg::ST_OK;
              end
            end
            otq_pkg::REQ_CHECK: begin
              if (!started_r && !(min_f_r && hint_r <= {20'd0, c_r.now})) begin
                // nothing runs
              end else if (!min_f_r) begin
                hint_nxt = otq_pkg::NO_EXPIRY;
                res_nxt.next_expiry = hint_nxt;
                if (nfired_r != '0) res_v_nxt = 1'b0;
              end else if (c_r.now < me ||
                           nfired_r == otq_pkg::NF_W'(otq_pkg::MAX_RESULTS)) begin
                hint_nxt = {20'd0, me};
                res_nxt.next_expiry = hint_nxt;
                if (nfired_r != '0) res_v_nxt = 1'b0;
              end else begin
                // fire the minimum, hold it until the next scan decides last
                res_v_nxt = res_v_r && !res_ready;
                st_nxt = otq_pkg::S_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      otq_pkg::S_EMIT: begin
        clr_en = 1'b1; clr_i = min_i_r;
        started_nxt = 1'b1;
        nfired_nxt = nfired_r + otq_pkg::NF_W'(1);
        st_nxt = otq_pkg::S_WAIT;
      end
      default: begin
        st_nxt = otq_pkg::S_SCAN; idx_nxt = '0;
        min_f_nxt = 1'b0; gt_f_nxt = 1'b0;
      end
    endcase
  end

  // pending fired word waits in pend_r until the following decision sets last;
  // every fired word carries the earliest expiry still in the future
  otq_pkg::res_t pend_r;
  logic pend_v_r;
  otq_pkg::res_t out_w;
  logic out_load;
  always_comb begin
    out_w = pend_r;
    out_load = 1'b0;
    if (pend_v_r && st_r == otq_pkg::S_ACT && (!res_v_r || res_ready)) begin
      out_load = 1'b1;
      out_w.last = (st_nxt == otq_pkg::S_IDLE);
      out_w.next_expiry = gt_f_r ? {20'd0, gt_e_r} : otq_pkg::NO_EXPIRY;
    end
  end

  always_ff @(posedge clk) begin
    c_r <= (st_r == otq_pkg::S_IDLE && cmd_valid) ? cmd : c_r;
    min_k_r <= min_k_nxt; free_i_r <= free_i_nxt; match_i_r <= match_i_nxt;
    min_i_r <= min_i_nxt; gt_e_r <= gt_e_nxt;
    rd_v_r <= valid_r[rd_addr];
    res_r <= out_load ? out_w : res_nxt;
    if (st_r == otq_pkg::S_EMIT) begin
      pend_r <= '{otq_pkg::ST_OK, min_k_r, tag_mem[min_i_r], 64'd0, 1'b0};
    end
    if (!rst_n) begin
      st_r <= otq_pkg::S_IDLE; valid_r <= '0; seq_r <= '0;
      hint_r <= otq_pkg::NO_EXPIRY; idx_r <= '0; rd_live_r <= 1'b0;
      free_f_r <= 1'b0; match_f_r <= 1'b0; min_f_r <= 1'b0; gt_f_r <= 1'b0;
      nfired_r <= '0; started_r <= 1'b0; res_v_r <= 1'b0; pend_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt; idx_r <= idx_nxt; hint_r <= hint_nxt;
      rd_live_r <= (st_r == otq_pkg::S_SCAN) && (idx_r != (SW+1)'(N));
      free_f_r <= free_f_nxt; match_f_r <= match_f_nxt; min_f_r <= min_f_nxt;
      gt_f_r <= gt_f_nxt;
      nfired_r <= nfired_nxt; started_r <= started_nxt;
      res_v_r <= res_v_nxt || out_load;
      if (out_load) pend_v_r <= 1'b0;
      else if (st_r == otq_pkg::S_EMIT) pend_v_r <= 1'b1;
      if (wr_en) valid_r[wr_i] <= 1'b1;
      if (clr_en) valid_r[clr_i] <= 1'b0;
      if (st_r == otq_pkg::S_ACT && st_nxt == otq_pkg::S_IDLE && c_r.req == otq_pkg::REQ_CREATE
          && !c_r.ovf && free_f_r)
        seq_r <= seq_r + otq_pkg::SEQ_W'(1);
    end
  end
endmodule

@@ src/otq_checker.sv @@
// port-level checks for the ordered timer queue, bound to the top level
// depends on ordered_timer_queue
`timescale 1ns / 1ps
module otq_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [1:0]   out_tuser,
  input logic [143:0] out_tdata,
  input logic         out_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");
  a_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != 2'd0 |-> out_tdata[79:64] == 16'd0)
    else $error("tag set on non-fired word");
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != 2'd0 |-> out_tlast)
    else $error("error status not final");
endmodule

bind ordered_timer_queue otq_checker u_otq_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tuser, .out_tdata, .out_tlast
);
